@@ hdl/grsg_pkg.sv @@
// Package for the grid run sort and group block.
// Holds sizes, the mark and result word layouts and the memory request type.
// No dependencies.
package grsg_pkg;

  localparam int MARK_CAPACITY = 32;
  localparam int RESULT_LIMIT  = 32;
  localparam int STORE_LIMIT   = (MARK_CAPACITY < RESULT_LIMIT) ? MARK_CAPACITY : RESULT_LIMIT;
  localparam int ADDR_W        = (STORE_LIMIT > 1) ? $clog2(STORE_LIMIT) : 1;
  localparam int CNT_W         = $clog2(STORE_LIMIT + 1);

  localparam int COL_W = 8;
  localparam int ROW_W = 8;
  localparam int PAT_W = 32;
  localparam int KEY_W = ROW_W + COL_W;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic [PAT_W-1:0] pattern;
  } mark_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    mark_t wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

  typedef struct packed {
    mark_t mark;
    logic  word_end;
    logic  set_end;
    logic  overflowed;
  } result_t;

  function automatic logic [KEY_W-1:0] mark_key(input mark_t m);
    mark_key = {m.row, m.column};
  endfunction

endpackage

@@ hdl/grsg_in_if.sv @@
// Input channel of the grid run sort and group block: one mark per word.
// Depends on grsg_pkg.
interface grsg_in_if;
  logic                       valid;
  logic                       ready;
  logic [grsg_pkg::COL_W-1:0] column;
  logic [grsg_pkg::ROW_W-1:0] row;
  logic [grsg_pkg::PAT_W-1:0] pattern;
  logic                       final_mark;

  modport source (output valid, column, row, pattern, final_mark, input ready);
  modport sink (input valid, column, row, pattern, final_mark, output ready);
endinterface

@@ hdl/grsg_out_if.sv @@
// Result channel of the grid run sort and group block: one sorted mark per word.
// Depends on grsg_pkg.
interface grsg_out_if;
  logic                       valid;
  logic                       ready;
  logic [grsg_pkg::COL_W-1:0] out_column;
  logic [grsg_pkg::ROW_W-1:0] out_row;
  logic [grsg_pkg::PAT_W-1:0] out_pattern;
  logic                       word_end;
  logic                       set_end;
  logic                       overflowed;

  modport source (output valid, out_column, out_row, out_pattern, word_end, set_end,
                  overflowed, input ready);
  modport sink (input valid, out_column, out_row, out_pattern, word_end, set_end,
                overflowed, output ready);
endinterface

@@ hdl/grid_run_sort_and_group_top.sv @@
// Top level of the grid run sort and group block.
// Depends on grsg_pkg, grsg_in_if, grsg_out_if, grsg_mark_ram, grsg_seq, grsg_out_reg.
//
//   Channel   Dir   Word                                              Handshake
//   in_ch     in    column, row, pattern, final_mark                  valid/ready
//   out_ch    out   out_column, out_row, out_pattern, word_end,        valid/ready
//                   set_end, overflowed
//
// Loading accepts one word per cycle. On the final mark the store of n marks is
// insertion-sorted through its one read port and one write port: each mark is read, and
// each larger mark before it is moved up one place before the mark is written back.
// Readout then gives one result word per cycle while out_ch is ready.
// Reset is synchronous and clears the count and overflow flag; the store is not cleared.
// in_ch is not ready during sorting and readout; a stalled out_ch holds readout.
module grid_run_sort_and_group_top (
  input  logic       clk,
  input  logic       rst_n,
  grsg_in_if.sink    in_ch,
  grsg_out_if.source out_ch
);
  import grsg_pkg::*;

  ram_req_t ram_req;
  mark_t    ram_rdata;
  mark_t    in_mark;
  logic     res_valid;
  logic     res_ready;
  result_t  res;

  assign in_mark.column  = in_ch.column;
  assign in_mark.row     = in_ch.row;
  assign in_mark.pattern = in_ch.pattern;

  grsg_mark_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  grsg_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_mark   (in_mark),
    .in_final  (in_ch.final_mark),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  grsg_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_ch    (out_ch)
  );
endmodule

@@ hdl/grsg_mark_ram.sv @@
// Mark store: one write port and one read port with registered read data.
// Depends on grsg_pkg.
module grsg_mark_ram (
  input  logic               clk,
  input  grsg_pkg::ram_req_t req,
  output grsg_pkg::mark_t    rdata
);
  import grsg_pkg::*;

  mark_t mem [STORE_LIMIT];
  mark_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

@@ hdl/grsg_seq.sv @@
// Sequencer: loads marks into the store, insertion-sorts them in place by
// row and column, then reads them out in order and flags word ends.
// Depends on grsg_pkg and drives grsg_mark_ram.
module grsg_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  grsg_pkg::mark_t    in_mark,
  input  logic               in_final,
  output grsg_pkg::ram_req_t ram_req,
  input  grsg_pkg::mark_t    ram_rdata,
  output logic               res_valid,
  input  logic               res_ready,
  output grsg_pkg::result_t  res
);
  import grsg_pkg::*;

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_SRD    = 3'd1;
  localparam logic [2:0] ST_CUR    = 3'd2;
  localparam logic [2:0] ST_CMP    = 3'd3;
  localparam logic [2:0] ST_PLACE  = 3'd4;
  localparam logic [2:0] ST_ERD    = 3'd5;
  localparam logic [2:0] ST_EFIRST = 3'd6;
  localparam logic [2:0] ST_ENEXT  = 3'd7;

  logic [2:0] state_r, state_nxt;
  cnt_t       cnt_r, cnt_nxt;
  logic       ovf_r, ovf_nxt;
  cnt_t       i_r, i_nxt;
  cnt_t       j_r, j_nxt;
  cnt_t       k_r, k_nxt;
  mark_t      cur_r, cur_nxt;
  mark_t      hold_r, hold_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    cur_r  <= cur_nxt;
    hold_r <= hold_nxt;
  end

  always_comb begin
    cnt_t             i_inc;
    cnt_t             i_dec;
    cnt_t             j_dec2;
    cnt_t             k_inc;
    logic [CNT_W:0]   k_add2;
    logic             last;
    logic             cont;

    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cur_nxt   = cur_r;
    hold_nxt  = hold_r;
    ram_req   = '0;
    in_ready  = (state_r == ST_LOAD);
    res_valid = 1'b0;

    i_inc  = i_r + cnt_t'(1);
    i_dec  = i_r - cnt_t'(1);
    j_dec2 = j_r - cnt_t'(2);
    k_inc  = k_r + cnt_t'(1);
    k_add2 = {1'b0, k_r} + (CNT_W+1)'(2);
    last   = (k_inc == cnt_r);
    cont   = (ram_rdata.row == hold_r.row) &&
             (ram_rdata.column == hold_r.column + COL_W'(1));

    res.mark       = hold_r;
    res.word_end   = last || !cont;
    res.set_end    = last;
    res.overflowed = ovf_r;

    case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (cnt_r < cnt_t'(STORE_LIMIT)) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = cnt_r[ADDR_W-1:0];
            ram_req.wdata = in_mark;
            cnt_nxt       = cnt_r + cnt_t'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_final) begin
            i_nxt = cnt_t'(1);
            if (cnt_nxt > cnt_t'(1)) begin
              state_nxt = ST_SRD;
            end else begin
              state_nxt = ST_ERD;
            end
          end
        end
      end
      ST_SRD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = i_r[ADDR_W-1:0];
        state_nxt     = ST_CUR;
      end
      ST_CUR: begin
        cur_nxt       = ram_rdata;
        j_nxt         = i_r;
        ram_req.re    = 1'b1;
        ram_req.raddr = i_dec[ADDR_W-1:0];
        state_nxt     = ST_CMP;
      end
      ST_CMP: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = j_r[ADDR_W-1:0];
        if (mark_key(ram_rdata) > mark_key(cur_r)) begin
          ram_req.wdata = ram_rdata;
          j_nxt         = j_r - cnt_t'(1);
          if (j_r == cnt_t'(1)) begin
            state_nxt = ST_PLACE;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = j_dec2[ADDR_W-1:0];
          end
        end else begin
          ram_req.wdata = cur_r;
          i_nxt         = i_inc;
          if (i_inc < cnt_r) begin
            ram_req.re    = 1'b1;
            ram_req.raddr = i_inc[ADDR_W-1:0];
            state_nxt     = ST_CUR;
          end else begin
            state_nxt = ST_ERD;
          end
        end
      end
      ST_PLACE: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = '0;
        ram_req.wdata = cur_r;
        i_nxt         = i_inc;
        if (i_inc < cnt_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = i_inc[ADDR_W-1:0];
          state_nxt     = ST_CUR;
        end else begin
          state_nxt = ST_ERD;
        end
      end
      ST_ERD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = '0;
        k_nxt         = '0;
        state_nxt     = ST_EFIRST;
      end
      ST_EFIRST: begin
        hold_nxt = ram_rdata;
        if (cnt_r > cnt_t'(1)) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = addr_t'(1);
        end
        state_nxt = ST_ENEXT;
      end
      ST_ENEXT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (last) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            hold_nxt = ram_rdata;
            k_nxt    = k_inc;
            if (k_add2 < {1'b0, cnt_r}) begin
              ram_req.re    = 1'b1;
              ram_req.raddr = k_add2[ADDR_W-1:0];
            end
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(STORE_LIMIT))
    else $error("Mark count exceeds the store size.");

  a_inner_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> (j_r != '0 && j_r <= i_r && i_r < cnt_r))
    else $error("Insertion index out of range.");

  a_set_close: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready && res.set_end) |=> (state_r == ST_LOAD && cnt_r == '0 && !ovf_r))
    else $error("Store not emptied after the last word of a set.");

  a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ENEXT) |-> (k_r < cnt_r))
    else $error("Readout index past the mark count.");
endmodule

@@ hdl/grsg_out_reg.sv @@
// Output register: holds one result word until the sink takes it.
// Depends on grsg_pkg and grsg_out_if.
module grsg_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  output logic              res_ready,
  input  grsg_pkg::result_t res,
  grsg_out_if.source        out_ch
);
  import grsg_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r, data_nxt;

  always_comb begin
    res_ready = !valid_r || out_ch.ready;
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (res_ready) begin
      valid_nxt = res_valid;
      if (res_valid) begin
        data_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.out_column  = data_r.mark.column;
  assign out_ch.out_row     = data_r.mark.row;
  assign out_ch.out_pattern = data_r.mark.pattern;
  assign out_ch.word_end    = data_r.word_end;
  assign out_ch.set_end     = data_r.set_end;
  assign out_ch.overflowed  = data_r.overflowed;
endmodule
